FILE: hw/rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg: shared constants and types for the configuration frame receiver
// Field widths, frame protocol bytes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // Widths of the item fields and of the frame position counter.
  localparam int CMD_W    = 1;
  localparam int BYTE_W   = 8;
  localparam int DEV_W    = 1;
  localparam int IDX_W    = 7;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 8;

  // Frame protocol bytes.
  localparam logic [BYTE_W-1:0] HEADER_BYTE  = 8'hAA;
  localparam logic [BYTE_W-1:0] COMMAND_BYTE = 8'h01;

  // Item kinds carried in the cmd field.
  localparam logic [CMD_W-1:0] CMD_HOST_BYTE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ      = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DISCARDED    = 3'd0,
    ST_TAKEN        = 3'd1,
    ST_ACCEPTED     = 3'd2,
    ST_BAD_COMMAND  = 3'd3,
    ST_BAD_CHECKSUM = 3'd4,
    ST_READ         = 3'd5
  } status_t;

  // Defaults for the top-level parameters.
  localparam int FRAME_BYTES_DEF         = 139;
  localparam int PAYLOAD_BYTES_DEF       = 136;
  localparam int CHANNELS_PER_DEVICE_DEF = 17;

endpackage

FILE: hw/rtl/cfr_in_if.sv
// ----------------------------------------------------------------------------
// cfr_in_if: input item channel
// Valid/ready channel carrying host bytes and routed read requests.
// ----------------------------------------------------------------------------
interface cfr_in_if;
  logic                        valid;
  logic                        ready;
  logic [cfr_pkg::CMD_W-1:0]   cmd;
  logic [cfr_pkg::BYTE_W-1:0]  rx_byte;
  logic [cfr_pkg::DEV_W-1:0]   device;
  logic [cfr_pkg::IDX_W-1:0]   cfg_index;

  modport source (output valid, cmd, rx_byte, device, cfg_index, input ready);
  modport sink   (input valid, cmd, rx_byte, device, cfg_index, output ready);
endinterface

FILE: hw/rtl/cfr_out_if.sv
// ----------------------------------------------------------------------------
// cfr_out_if: result item channel
// Valid/ready channel carrying one status result per input item.
// ----------------------------------------------------------------------------
interface cfr_out_if;
  logic                          valid;
  logic                          ready;
  logic [cfr_pkg::STATUS_W-1:0]  status;
  logic [cfr_pkg::BYTE_W-1:0]    read_byte;
  logic                          config_valid;

  modport source (output valid, status, read_byte, config_valid, input ready);
  modport sink   (input valid, status, read_byte, config_valid, output ready);
endinterface

FILE: hw/rtl/cfr_ram.sv
// ----------------------------------------------------------------------------
// cfr_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 272,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/cfr_route.sv
// ----------------------------------------------------------------------------
// cfr_route: routed read offset
// Splits the image index into group and channel and forms the payload offset.
// ----------------------------------------------------------------------------
module cfr_route #(
  parameter int PAYLOAD_BYTES       = cfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int CHANNELS_PER_DEVICE = cfr_pkg::CHANNELS_PER_DEVICE_DEF,
  localparam int OFF_W = $clog2(256 * CHANNELS_PER_DEVICE)
) (
  input  logic [cfr_pkg::DEV_W-1:0] device,
  input  logic [cfr_pkg::IDX_W-1:0] cfg_index,
  output logic [OFF_W-1:0]          offset,
  output logic                      in_range
);

  localparam logic [cfr_pkg::IDX_W-1:0] CPD = cfr_pkg::IDX_W'(CHANNELS_PER_DEVICE);

  // Reciprocal constant for the division by the channel count. With the shift
  // set to the index width plus the bits of the divisor, the rounded-up
  // reciprocal gives the exact quotient for every seven-bit index.
  localparam int SHIFT  = cfr_pkg::IDX_W + $clog2(CHANNELS_PER_DEVICE);
  localparam int RECIP  = ((1 << SHIFT) + CHANNELS_PER_DEVICE - 1) / CHANNELS_PER_DEVICE;
  localparam int PROD_W = cfr_pkg::IDX_W + SHIFT + 1;

  logic [PROD_W-1:0]         prod;
  logic [cfr_pkg::IDX_W-1:0] rem_v;
  logic [cfr_pkg::IDX_W-1:0] quo_v;

  assign prod  = PROD_W'(cfg_index) * PROD_W'(RECIP);
  assign quo_v = cfr_pkg::IDX_W'(prod >> SHIFT);
  assign rem_v = cfg_index - cfr_pkg::IDX_W'(quo_v * CPD);

  // offset = group * 2 * CPD + device * CPD + channel = (2*group + device) * CPD + rem
  assign offset   = OFF_W'({quo_v, device}) * OFF_W'(CHANNELS_PER_DEVICE)
                  + OFF_W'(rem_v);
  assign in_range = (offset < OFF_W'(PAYLOAD_BYTES));

endmodule

FILE: hw/rtl/config_frame_receiver_router.sv
// ----------------------------------------------------------------------------
// config_frame_receiver_router: host configuration frame receiver and router
// Assembles checksummed configuration frames into a double-buffered store and
// serves per-device routed reads from the live half.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_bus, one per transfer. An item with cmd low carries
// one host byte; an item with cmd high asks for one routed configuration byte
// of a device. Every input transfer yields exactly one result transfer on
// out_bus, in order, with a status code, the read byte (zero for host bytes)
// and the config_valid flag.
// Result path: an accepted item is registered in stage 1 while the store read
// completes, then moves to the output register, which drives out_bus; a
// stalled sink can hold it in either register.
// Throughput: one item per cycle while the result sink keeps up. The only
// memory is the payload store, with one write port for incoming payload bytes
// and one read port for routed reads; an item uses at most one of them.
// Reset (rst_n low, synchronous) returns the receiver to hunting for a header,
// clears the bank select and config_valid, and empties the result pipeline.
// The store itself is not cleared.
// Stalls: the result path has a pipeline stage and an output register, so
// in_bus.ready stays high while a result waits, until both hold an item.
// ----------------------------------------------------------------------------
module config_frame_receiver_router #(
  parameter int FRAME_BYTES         = cfr_pkg::FRAME_BYTES_DEF,
  parameter int PAYLOAD_BYTES       = cfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int CHANNELS_PER_DEVICE = cfr_pkg::CHANNELS_PER_DEVICE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cfr_in_if.sink     in_bus,
  cfr_out_if.source  out_bus
);

  localparam int DEPTH  = 2 * PAYLOAD_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OFF_W  = $clog2(256 * CHANNELS_PER_DEVICE);
  localparam int POS_W  = cfr_pkg::POS_W;
  localparam int BYTE_W = cfr_pkg::BYTE_W;

  localparam logic [POS_W-1:0]  LAST_POS    = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0]  PAYLOAD_LEN = POS_W'(PAYLOAD_BYTES);
  localparam logic [ADDR_W-1:0] BANK_BASE   = ADDR_W'(PAYLOAD_BYTES);

  // Frame receiver state.
  logic              in_frame_r,    in_frame_nxt;
  logic [POS_W-1:0]  pos_r,         pos_nxt;
  logic [BYTE_W-1:0] sum_r,         sum_nxt;
  logic              cmd_ok_r,      cmd_ok_nxt;
  logic              live_bank_r,   live_bank_nxt;
  logic              have_config_r, have_config_nxt;

  // Result pipeline: stage 1 waits on the store read, stage 2 is the output.
  logic                  s1_v_r;
  cfr_pkg::status_t      s1_status_r;
  logic                  s1_cfgv_r;
  logic                  s1_rd_r;
  logic                  s2_v_r;
  logic [cfr_pkg::STATUS_W-1:0] s2_status_r;
  logic [BYTE_W-1:0]     s2_byte_r;
  logic                  s2_cfgv_r;

  logic              accept;
  logic              is_read;
  logic              s1_adv;
  cfr_pkg::status_t  status_c;

  // Store ports.
  logic              ram_we;
  logic [POS_W-1:0]  wr_off;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [OFF_W-1:0]  rd_off;
  logic              rd_in_range;

  // Both result registers full and the sink stalled is the only case in which
  // an item is held off.
  assign s1_adv       = !s2_v_r || out_bus.ready;
  assign in_bus.ready = !s1_v_r || s1_adv;
  assign accept       = in_bus.valid && in_bus.ready;
  assign is_read      = (in_bus.cmd == cfr_pkg::CMD_READ);

  // Host byte handling: header hunt, command check, payload capture into the
  // inactive bank and the checksum decision on the last byte; reads get ST_READ.
  always_comb begin
    in_frame_nxt    = in_frame_r;
    pos_nxt         = pos_r;
    sum_nxt         = sum_r;
    cmd_ok_nxt      = cmd_ok_r;
    live_bank_nxt   = live_bank_r;
    have_config_nxt = have_config_r;
    status_c        = cfr_pkg::ST_DISCARDED;
    ram_we          = 1'b0;
    wr_off          = pos_r - POS_W'(2);

    if (accept && is_read) begin
      status_c = cfr_pkg::ST_READ;
    end else if (accept) begin
      if (!in_frame_r) begin
        if (in_bus.rx_byte == cfr_pkg::HEADER_BYTE) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = POS_W'(1);
          sum_nxt      = in_bus.rx_byte;
          cmd_ok_nxt   = 1'b0;
          status_c     = cfr_pkg::ST_TAKEN;
        end
      end else if (pos_r >= LAST_POS) begin
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        if (!cmd_ok_r) begin
          status_c = cfr_pkg::ST_BAD_COMMAND;
        end else if (sum_r != in_bus.rx_byte) begin
          status_c = cfr_pkg::ST_BAD_CHECKSUM;
        end else begin
          live_bank_nxt   = !live_bank_r;
          have_config_nxt = 1'b1;
          status_c        = cfr_pkg::ST_ACCEPTED;
        end
      end else begin
        if (pos_r == POS_W'(1)) begin
          cmd_ok_nxt = (in_bus.rx_byte == cfr_pkg::COMMAND_BYTE);
        end else if (wr_off < PAYLOAD_LEN) begin
          // Payload bytes beyond the store are summed but not kept.
          ram_we = 1'b1;
        end
        sum_nxt  = sum_r + in_bus.rx_byte;
        pos_nxt  = pos_r + POS_W'(1);
        status_c = cfr_pkg::ST_TAKEN;
      end
    end
  end

  // Writes always go to the inactive bank and reads to the live one, and the
  // bank only flips on the checksum byte, after the last payload write has
  // landed. A read and a write never hit the same entry in one cycle, so the
  // store needs no forwarding.
  assign ram_waddr = ADDR_W'(wr_off) + (live_bank_r ? '0 : BANK_BASE);
  assign ram_re    = accept && is_read;
  assign ram_raddr = ADDR_W'(rd_off) + (live_bank_r ? BANK_BASE : '0);

  cfr_route #(
    .PAYLOAD_BYTES       (PAYLOAD_BYTES),
    .CHANNELS_PER_DEVICE (CHANNELS_PER_DEVICE)
  ) u_route (
    .device    (in_bus.device),
    .cfg_index (in_bus.cfg_index),
    .offset    (rd_off),
    .in_range  (rd_in_range)
  );

  cfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_bus.rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r    <= 1'b0;
      pos_r         <= '0;
      sum_r         <= '0;
      cmd_ok_r      <= 1'b0;
      live_bank_r   <= 1'b0;
      have_config_r <= 1'b0;
    end else begin
      in_frame_r    <= in_frame_nxt;
      pos_r         <= pos_nxt;
      sum_r         <= sum_nxt;
      cmd_ok_r      <= cmd_ok_nxt;
      live_bank_r   <= live_bank_nxt;
      have_config_r <= have_config_nxt;
    end
  end

  // Stage 1 valid and stage 2 valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_bus.ready) begin
        s1_v_r <= in_bus.valid;
      end
      if (s1_adv) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  // Payload registers. The store holds its read data until the next read,
  // which cannot start while stage 1 is stuck, so stage 1 needs no copy.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status_c;
      s1_cfgv_r   <= have_config_nxt;
      s1_rd_r     <= is_read && rd_in_range;
    end
    if (s1_v_r && s1_adv) begin
      s2_status_r <= s1_status_r;
      s2_byte_r   <= s1_rd_r ? ram_rdata : '0;
      s2_cfgv_r   <= s1_cfgv_r;
    end
  end

  assign out_bus.valid        = s2_v_r;
  assign out_bus.status       = s2_status_r;
  assign out_bus.read_byte    = s2_byte_r;
  assign out_bus.config_valid = s2_cfgv_r;

`ifndef ASSERT_OFF
  // A payload write never coincides with a routed read, and never targets the live bank.
  a_write_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !(accept && is_read))
    else $error("store write collides with a routed read");

  a_write_bank: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((ram_waddr >= BANK_BASE) != live_bank_r))
    else $error("payload write targets the live bank");

  // Once a frame has been accepted, config_valid stays set until reset.
  a_config_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(have_config_r) |-> have_config_r)
    else $error("config_valid dropped without reset");

  // A new output result only appears when stage 1 held an item.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && s2_v_r && !$past(s2_v_r) |-> $past(s1_v_r))
    else $error("result appeared with no item in flight");

  // With the output register empty the block always takes input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_v_r |-> in_bus.ready)
    else $error("input held off with an empty output register");
`endif

endmodule

FILE: tb/sv/tb_config_frame_receiver_router.sv
// ----------------------------------------------------------------------------
// tb_config_frame_receiver_router: self-checking bench for the frame receiver
// Streams host bytes and routed reads into the receiver with random gaps on
// both channels. Expected results come from a cycle-free model of the framer,
// the double-buffered payload store and the per-device read routing.
// ----------------------------------------------------------------------------
module tb_config_frame_receiver_router;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CMD_W               = cfr_pkg::CMD_W;
  localparam int BYTE_W              = cfr_pkg::BYTE_W;
  localparam int DEV_W               = cfr_pkg::DEV_W;
  localparam int IDX_W               = cfr_pkg::IDX_W;
  localparam int POS_W               = cfr_pkg::POS_W;
  localparam int FRAME_BYTES         = cfr_pkg::FRAME_BYTES_DEF;
  localparam int PAYLOAD_BYTES       = cfr_pkg::PAYLOAD_BYTES_DEF;
  localparam int CHANNELS_PER_DEVICE = cfr_pkg::CHANNELS_PER_DEVICE_DEF;
  localparam int TOTAL_ITEMS         = 1500;
  localparam int MAX_GAP             = 6;
  localparam int MAX_REPORTS         = 10;
  localparam int IDX_TOP             = (1 << IDX_W) - 1;

  // One input item as it goes over in_bus; drain asks the driver to hold it
  // back until every result of the items before it has come out.
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] rx_byte;
    logic [DEV_W-1:0]  device;
    logic [IDX_W-1:0]  cfg_index;
    bit                drain;
  } rx_item_t;

  typedef struct {
    cfr_pkg::status_t  status;
    logic [BYTE_W-1:0] read_byte;
    logic              config_valid;
  } rx_result_t;

  typedef enum {FRAME_GOOD, FRAME_BAD_CMD, FRAME_BAD_SUM, FRAME_BAD_BOTH} frame_kind_t;
  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_HEADER, FILL_RAMP} fill_t;

  logic clk;
  logic rst_n;

  cfr_in_if  in_bus ();
  cfr_out_if out_bus ();

  config_frame_receiver_router #(
    .FRAME_BYTES         (FRAME_BYTES),
    .PAYLOAD_BYTES       (PAYLOAD_BYTES),
    .CHANNELS_PER_DEVICE (CHANNELS_PER_DEVICE)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Receiver model. It mirrors the framer state, the two payload halves and
  // the live-half select. It is only advanced by the monitor, once per input
  // transfer, so it always sits exactly where the block is in the stream.
  // --------------------------------------------------------------------------
  logic                 frm_active;
  logic [POS_W-1:0]     frm_pos;
  logic [BYTE_W-1:0]    frm_sum;
  logic                 frm_cmd_ok;
  logic                 live_half;
  logic                 have_image;
  logic [BYTE_W-1:0]    image_mem [0:2*PAYLOAD_BYTES-1];

  // Offset into one payload half for a device's image byte. The payload is
  // laid out in groups of two channel blocks, one block per device.
  function automatic int unsigned routed_offset(input logic [DEV_W-1:0] dev,
                                                input logic [IDX_W-1:0] idx);
    int unsigned grp;
    int unsigned chan;
    grp  = idx / CHANNELS_PER_DEVICE;
    chan = dev * CHANNELS_PER_DEVICE + idx % CHANNELS_PER_DEVICE;
    return grp * 2 * CHANNELS_PER_DEVICE + chan;
  endfunction

  function automatic rx_result_t receiver_outcome(input rx_item_t it);
    rx_result_t  r;
    int unsigned off;
    r.status    = cfr_pkg::ST_DISCARDED;
    r.read_byte = '0;
    if (it.cmd == cfr_pkg::CMD_READ) begin
      // Reads always see the live half, even in the middle of a frame.
      r.status = cfr_pkg::ST_READ;
      off = routed_offset(it.device, it.cfg_index);
      if (off < PAYLOAD_BYTES) begin
        r.read_byte = image_mem[live_half * PAYLOAD_BYTES + off];
      end
    end else if (!frm_active) begin
      // Hunting: only the header byte opens a frame.
      if (it.rx_byte == cfr_pkg::HEADER_BYTE) begin
        frm_active = 1'b1;
        frm_pos    = POS_W'(1);
        frm_sum    = cfr_pkg::HEADER_BYTE;
        frm_cmd_ok = 1'b0;
        r.status   = cfr_pkg::ST_TAKEN;
      end
    end else if (frm_pos >= FRAME_BYTES - 1) begin
      // Checksum byte closes the frame. A bad command outranks a bad sum.
      frm_active = 1'b0;
      frm_pos    = '0;
      if (!frm_cmd_ok) begin
        r.status = cfr_pkg::ST_BAD_COMMAND;
      end else if (frm_sum != it.rx_byte) begin
        r.status = cfr_pkg::ST_BAD_CHECKSUM;
      end else begin
        live_half  = ~live_half;
        have_image = 1'b1;
        r.status   = cfr_pkg::ST_ACCEPTED;
      end
    end else begin
      if (frm_pos == 1) begin
        frm_cmd_ok = (it.rx_byte == cfr_pkg::COMMAND_BYTE);
      end else if (frm_pos - 2 < PAYLOAD_BYTES) begin
        image_mem[(!live_half) * PAYLOAD_BYTES + frm_pos - 2] = it.rx_byte;
      end
      frm_sum  = frm_sum + it.rx_byte;
      frm_pos  = frm_pos + 1'b1;
      r.status = cfr_pkg::ST_TAKEN;
    end
    r.config_valid = have_image;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation. The generator only needs to know whether a good
  // frame has gone in ahead of a read, so that no read ever lands on a store
  // entry that has never been written.
  // --------------------------------------------------------------------------
  rx_item_t item_q [$];
  int       queued;
  bit       drain_next;
  bit       gen_have_image;

  task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                          input logic [DEV_W-1:0] dev, input logic [IDX_W-1:0] idx);
    rx_item_t it;
    it.cmd       = cmd;
    it.rx_byte   = b;
    it.device    = dev;
    it.cfg_index = idx;
    it.drain     = drain_next;
    drain_next   = 1'b0;
    item_q.push_back(it);
    queued++;
  endtask

  // Host byte; the read fields are don't-care and get random values.
  task automatic add_host(input logic [BYTE_W-1:0] b);
    add_item(cfr_pkg::CMD_HOST_BYTE, b, DEV_W'($urandom), IDX_W'($urandom));
  endtask

  // Before the first good frame only reads that fall past the payload are
  // allowed, since those never touch the store.
  task automatic add_read(input logic [DEV_W-1:0] dev, input logic [IDX_W-1:0] idx);
    while (!gen_have_image && routed_offset(dev, idx) < PAYLOAD_BYTES) begin
      idx = IDX_W'($urandom_range(0, IDX_TOP));
    end
    add_item(cfr_pkg::CMD_READ, BYTE_W'($urandom), dev, idx);
  endtask

  task automatic add_noise(input int count);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < count; i++) begin
      b = BYTE_W'($urandom);
      if (b == cfr_pkg::HEADER_BYTE) b = ~b;
      add_host(b);
    end
  endtask

  task automatic sprinkle_reads(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      repeat ($urandom_range(1, 3)) add_read(DEV_W'($urandom), IDX_W'($urandom));
    end
  endtask

  // A complete frame of FRAME_BYTES bytes, optionally with reads woven in.
  task automatic add_frame(input frame_kind_t kind, input fill_t fill, input int read_pct);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] cmd_b;
    add_host(cfr_pkg::HEADER_BYTE);
    sum   = cfr_pkg::HEADER_BYTE;
    cmd_b = cfr_pkg::COMMAND_BYTE;
    if (kind == FRAME_BAD_CMD || kind == FRAME_BAD_BOTH) begin
      do cmd_b = BYTE_W'($urandom); while (cmd_b == cfr_pkg::COMMAND_BYTE);
    end
    sprinkle_reads(read_pct);
    add_host(cmd_b);
    sum += cmd_b;
    for (int i = 0; i < FRAME_BYTES - 3; i++) begin
      case (fill)
        FILL_ZERO:   b = 8'h00;
        FILL_ONES:   b = 8'hFF;
        FILL_HEADER: b = cfr_pkg::HEADER_BYTE;
        FILL_RAMP:   b = BYTE_W'(i + 16);
        default:     b = BYTE_W'($urandom);
      endcase
      sprinkle_reads(read_pct);
      add_host(b);
      sum += b;
    end
    if (kind == FRAME_BAD_SUM || kind == FRAME_BAD_BOTH) begin
      sum += BYTE_W'($urandom_range(1, 255));
    end
    sprinkle_reads(read_pct);
    add_host(sum);
    if (kind == FRAME_GOOD) gen_have_image = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Input driver. Each item is followed by a random gap, except during calm
  // stretches. An item marked for draining waits until the output side has
  // caught up with everything sent so far.
  // --------------------------------------------------------------------------
  int       items_sent;
  int       results_seen;
  int       src_wait;
  bit       src_calm;
  int       taken_total;
  rx_item_t cur_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      src_wait     <= 0;
      items_sent   <= 0;
    end else if (!in_bus.valid || in_bus.ready) begin
      taken_total = items_sent + ((in_bus.valid && in_bus.ready) ? 1 : 0);
      items_sent <= taken_total;
      if (src_wait != 0) begin
        in_bus.valid <= 1'b0;
        src_wait     <= src_wait - 1;
      end else if (item_q.size() != 0 && !(item_q[0].drain && taken_total != results_seen)) begin
        cur_item = item_q.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.cmd       <= cur_item.cmd;
        in_bus.rx_byte   <= cur_item.rx_byte;
        in_bus.device    <= cur_item.device;
        in_bus.cfg_index <= cur_item.cfg_index;
        src_wait         <= src_calm ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 39) == 0) src_calm <= !src_calm;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink. After each transfer it may stall for a random number of
  // cycles; calm stretches keep ready high throughout.
  // --------------------------------------------------------------------------
  int sink_wait;
  int sink_draw;
  bit sink_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      sink_wait     <= 0;
    end else if (sink_wait != 0) begin
      out_bus.ready <= 1'b0;
      sink_wait     <= sink_wait - 1;
    end else if (out_bus.valid && out_bus.ready) begin
      sink_draw = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
      out_bus.ready <= (sink_draw == 0);
      sink_wait     <= (sink_draw == 0) ? 0 : sink_draw - 1;
      if ($urandom_range(0, 39) == 0) sink_calm <= !sink_calm;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Every input transfer advances the model and queues the expected
  // result; every output transfer is checked against the oldest one.
  // --------------------------------------------------------------------------
  rx_result_t outcome_q [$];
  rx_result_t want;
  int         errors;
  int         n_accepted;
  int         n_rejected;
  int         n_reads;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        want = receiver_outcome(rx_item_t'{in_bus.cmd, in_bus.rx_byte, in_bus.device,
                                           in_bus.cfg_index, 1'b0});
        case (want.status)
          cfr_pkg::ST_ACCEPTED:                              n_accepted++;
          cfr_pkg::ST_BAD_COMMAND, cfr_pkg::ST_BAD_CHECKSUM: n_rejected++;
          cfr_pkg::ST_READ:                                  n_reads++;
          default: ;
        endcase
        outcome_q.push_back(want);
      end
      if (out_bus.valid && out_bus.ready) begin
        results_seen <= results_seen + 1;
        if (outcome_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("[%0t] unexpected result: status %0d byte %02h valid %0d", $realtime,
                     out_bus.status, out_bus.read_byte, out_bus.config_valid);
          end
        end else begin
          want = outcome_q.pop_front();
          if (out_bus.status !== want.status || out_bus.read_byte !== want.read_byte ||
              out_bus.config_valid !== want.config_valid) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("[%0t] result %0d: expected status %0d byte %02h valid %0d, got %s",
                       $realtime, results_seen, want.status, want.read_byte,
                       want.config_valid,
                       $sformatf("status %0d byte %02h valid %0d", out_bus.status,
                                 out_bus.read_byte, out_bus.config_valid));
            end
          end
        end
      end
    end
  end

  // Safety net in case the handshake locks up.
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence: directed frames and reads first, then random traffic.
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    frame_kind_t kind;
    fill_t       fill;

    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.cmd        = cfr_pkg::CMD_HOST_BYTE;
    in_bus.rx_byte    = '0;
    in_bus.device     = '0;
    in_bus.cfg_index  = '0;
    out_bus.ready     = 1'b0;
    errors            = 0;
    results_seen      = 0;
    queued            = 0;
    drain_next        = 1'b0;
    gen_have_image    = 1'b0;
    src_calm          = 1'b0;
    sink_calm         = 1'b0;
    frm_active        = 1'b0;
    frm_pos           = '0;
    frm_sum           = '0;
    frm_cmd_ok        = 1'b0;
    live_half         = 1'b0;
    have_image        = 1'b0;

    // Reads before any image exists must fall past the payload; these return
    // zero. Then a few bytes that hunting discards.
    add_read(1'b0, IDX_W'(IDX_TOP));
    add_read(1'b1, IDX_W'(4 * CHANNELS_PER_DEVICE));
    add_noise(0);
    add_host(8'h00);
    add_host(8'hFF);
    add_host(8'h55);

    // First good frame with a ramp payload, so every routed byte is distinct.
    add_frame(FRAME_GOOD, FILL_RAMP, 3);

    // Routed reads at group and image boundaries for both devices, including
    // indexes past the end of the image.
    for (int d = 0; d < 2; d++) begin
      add_read(DEV_W'(d), IDX_W'(0));
      add_read(DEV_W'(d), IDX_W'(CHANNELS_PER_DEVICE - 1));
      add_read(DEV_W'(d), IDX_W'(CHANNELS_PER_DEVICE));
      add_read(DEV_W'(d), IDX_W'(4 * CHANNELS_PER_DEVICE - 1));
      add_read(DEV_W'(d), IDX_W'(4 * CHANNELS_PER_DEVICE));
      add_read(DEV_W'(d), IDX_W'(IDX_TOP));
    end

    // Rejected frames: wrong command with wrong sum, wrong sum alone (with
    // header bytes inside the frame), wrong command alone. Reads woven into the
    // first one must keep returning the live half.
    add_frame(FRAME_BAD_BOTH, FILL_RANDOM, 10);
    add_frame(FRAME_BAD_SUM, FILL_HEADER, 0);
    add_frame(FRAME_BAD_CMD, FILL_ZERO, 0);

    // Let the pipeline empty before the next reads go in.
    drain_next = 1'b1;
    add_read(1'b0, IDX_W'(0));
    add_read(1'b1, IDX_W'(4 * CHANNELS_PER_DEVICE - 1));
    add_frame(FRAME_GOOD, FILL_ONES, 0);
    add_read(1'b0, IDX_W'(1));
    add_read(1'b1, IDX_W'(2 * CHANNELS_PER_DEVICE));

    // Random traffic: mostly whole frames with random content, plus read
    // bursts and line noise between them.
    while (queued < TOTAL_ITEMS) begin
      if ($urandom_range(0, 19) == 0) drain_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pick = $urandom_range(0, 99);
        kind = (pick < 70) ? FRAME_GOOD : (pick < 80) ? FRAME_BAD_CMD :
               (pick < 90) ? FRAME_BAD_SUM : FRAME_BAD_BOTH;
        case ($urandom_range(0, 9))
          0:       fill = FILL_ZERO;
          1:       fill = FILL_ONES;
          2:       fill = FILL_HEADER;
          3:       fill = FILL_RAMP;
          default: fill = FILL_RANDOM;
        endcase
        add_frame(kind, fill, $urandom_range(0, 15));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 8)) add_read(DEV_W'($urandom), IDX_W'($urandom));
      end else begin
        add_noise($urandom_range(1, 8));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the driver to run dry, then for every result to come back,
    // then a little longer to catch any stray result.
    while (item_q.size() != 0 || in_bus.valid) @(posedge clk);
    while (results_seen != items_sent) @(posedge clk);
    repeat (20) @(posedge clk);

    if (outcome_q.size() != 0) begin
      $display("%0d expected results never arrived", outcome_q.size());
      errors += outcome_q.size();
    end

    $display("Sent %0d transfers: %0d frames accepted, %0d frames rejected, %0d reads.",
             items_sent, n_accepted, n_rejected, n_reads);
    $display("Errors found: %0d.", errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_in_if.sv
hw/rtl/cfr_out_if.sv
hw/rtl/cfr_ram.sv
hw/rtl/cfr_route.sv
hw/rtl/config_frame_receiver_router.sv
tb/sv/tb_config_frame_receiver_router.sv
